// ----- design/rvex_pkg.sv -----
package rvex_pkg;

    // Operation codes.
    localparam logic [4:0] OP_ADD    = 5'd0;
    localparam logic [4:0] OP_SUB    = 5'd1;
    localparam logic [4:0] OP_SLL    = 5'd2;
    localparam logic [4:0] OP_SLT    = 5'd3;
    localparam logic [4:0] OP_SLTU   = 5'd4;
    localparam logic [4:0] OP_XOR    = 5'd5;
    localparam logic [4:0] OP_SRL    = 5'd6;
    localparam logic [4:0] OP_SRA    = 5'd7;
    localparam logic [4:0] OP_OR     = 5'd8;
    localparam logic [4:0] OP_AND    = 5'd9;
    localparam logic [4:0] OP_LUI    = 5'd10;
    localparam logic [4:0] OP_AUIPC  = 5'd11;
    localparam logic [4:0] OP_MUL    = 5'd12;
    localparam logic [4:0] OP_MULH   = 5'd13;
    localparam logic [4:0] OP_MULHSU = 5'd14;
    localparam logic [4:0] OP_MULHU  = 5'd15;
    localparam logic [4:0] OP_DIV    = 5'd16;
    localparam logic [4:0] OP_DIVU   = 5'd17;
    localparam logic [4:0] OP_REM    = 5'd18;
    localparam logic [4:0] OP_REMU   = 5'd19;
    localparam logic [4:0] OP_BEQ    = 5'd20;
    localparam logic [4:0] OP_BNE    = 5'd21;
    localparam logic [4:0] OP_BLT    = 5'd22;
    localparam logic [4:0] OP_BGE    = 5'd23;
    localparam logic [4:0] OP_BLTU   = 5'd24;
    localparam logic [4:0] OP_BGEU   = 5'd25;
    localparam logic [4:0] OP_JAL    = 5'd26;
    localparam logic [4:0] OP_JALR   = 5'd27;

    localparam int XLEN = 32;
    localparam int QUEUE_DEPTH = 4;

    // Unit class chosen by the front end.
    localparam logic [1:0] CLS_ALU = 2'd0;
    localparam logic [1:0] CLS_MUL = 2'd1;
    localparam logic [1:0] CLS_DIV = 2'd2;

    // Classified instruction handed from the front to the back.
    typedef struct packed {
        logic [1:0]      cls;
        logic [4:0]      op;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] alu_value;
        logic            taken;
        logic [XLEN-1:0] target;
    } t_item;

endpackage

// ----- design/rv32im_execute_alu_muldiv_branch_core.sv -----
// RV32IM execute unit. ALU, shift, compare, branch and jump instructions, and
// multiplies, flow at one beat per cycle when no output stall or divide holds
// them, through the queue, the stage register and the output register. A
// divide or remainder runs in a radix-2 iterative divider, one quotient bit
// per cycle; the next beat leaves the queue only once the divide result has
// moved on to the output register. Meanwhile up to P_QUEUE_DEPTH beats (four by
// default) are still taken into the queue. Results leave in input order.
module rv32im_execute_alu_muldiv_branch_core
    import rvex_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [4:0]      i_operation,
    input  logic [XLEN-1:0] i_first_operand,
    input  logic [XLEN-1:0] i_second_operand,
    input  logic [XLEN-1:0] i_immediate,
    input  logic [XLEN-1:0] i_program_counter,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [XLEN-1:0] o_result_value,
    output logic            o_branch_taken,
    output logic [XLEN-1:0] o_branch_target
);
    t_item f_item, q_item;
    logic  q_full, q_valid, q_pop;

    rvex_front u_front (
        .i_operation      (i_operation),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_immediate      (i_immediate),
        .i_program_counter(i_program_counter),
        .o_item           (f_item)
    );

    assign o_stall = q_full;

    rvex_queue #(.DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_valid && !q_full),
        .i_item (f_item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_item (q_item)
    );

    rvex_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_branch_taken (o_branch_taken),
        .o_branch_target(o_branch_target)
    );
endmodule

// ----- design/rvex_front.sv -----
// Front end: evaluates ALU, compare and branch work combinationally and tags
// multiply and divide instructions for the back end.
module rvex_front
    import rvex_pkg::*;
(
    input  logic [4:0]      i_operation,
    input  logic [XLEN-1:0] i_first_operand,
    input  logic [XLEN-1:0] i_second_operand,
    input  logic [XLEN-1:0] i_immediate,
    input  logic [XLEN-1:0] i_program_counter,
    output t_item           o_item
);
    logic [XLEN-1:0] a, b, sum_pc, link, jtarget;
    logic [4:0]      sh;
    logic            slt, sltu;

    assign a       = i_first_operand;
    assign b       = i_second_operand;
    assign sh      = b[4:0];
    assign slt     = $signed(a) < $signed(b);
    assign sltu    = a < b;
    assign sum_pc  = i_program_counter + i_immediate;
    assign link    = i_program_counter + XLEN'(4);
    assign jtarget = (a + i_immediate) & ~XLEN'(1);

    // Decode and evaluate one instruction.
    always_comb begin
        o_item.cls       = CLS_ALU;
        o_item.op        = i_operation;
        o_item.a         = a;
        o_item.b         = b;
        o_item.alu_value = '0;
        o_item.taken     = 1'b0;
        o_item.target    = sum_pc;
        unique case (i_operation)
            OP_ADD:    o_item.alu_value = a + b;
            OP_SUB:    o_item.alu_value = a - b;
            OP_SLL:    o_item.alu_value = a << sh;
            OP_SLT:    o_item.alu_value = XLEN'(slt);
            OP_SLTU:   o_item.alu_value = XLEN'(sltu);
            OP_XOR:    o_item.alu_value = a ^ b;
            OP_SRL:    o_item.alu_value = a >> sh;
            OP_SRA:    o_item.alu_value = XLEN'($signed(a) >>> sh);
            OP_OR:     o_item.alu_value = a | b;
            OP_AND:    o_item.alu_value = a & b;
            OP_LUI:    o_item.alu_value = i_immediate;
            OP_AUIPC:  o_item.alu_value = sum_pc;
            OP_BEQ:    o_item.taken = (a == b);
            OP_BNE:    o_item.taken = (a != b);
            OP_BLT:    o_item.taken = slt;
            OP_BGE:    o_item.taken = !slt;
            OP_BLTU:   o_item.taken = sltu;
            OP_BGEU:   o_item.taken = !sltu;
            OP_JAL: begin
                o_item.taken     = 1'b1;
                o_item.alu_value = link;
            end
            OP_JALR: begin
                o_item.taken     = 1'b1;
                o_item.alu_value = link;
                o_item.target    = jtarget;
            end
            OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU: o_item.cls = CLS_MUL;
            OP_DIV, OP_DIVU, OP_REM, OP_REMU:     o_item.cls = CLS_DIV;
            default: ;
        endcase
        // A conditional branch reports its condition as the value.
        if (i_operation >= OP_BEQ && i_operation <= OP_BGEU) begin
            o_item.alu_value = XLEN'(o_item.taken);
        end
    end
endmodule

// ----- design/rvex_queue.sv -----
// Small FIFO between front and back; a full queue stalls the input.
module rvex_queue
    import rvex_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count out of range");
endmodule

// ----- design/rvex_back.sv -----
// Back end: a stage register and an output register. Multiplies form the
// full unsigned 32x32 product in stage 1 and apply the signed high-half
// corrections on the way into the output register. Divides and remainders
// run a radix-2 restoring divider, one quotient bit per cycle until all 32 bits
// are formed, and no further beat enters stage 1 until the divide result has moved into
// the output register.
module rvex_back
    import rvex_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_item           i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [XLEN-1:0] o_result_value,
    output logic            o_branch_taken,
    output logic [XLEN-1:0] o_branch_target
);
    localparam int CW = $clog2(XLEN + 1);

    // Stage 1: registered item and raw unsigned 32x32 product.
    logic            r_v1;
    t_item           r_i1;
    logic [2*XLEN-1:0] r_prod;

    // Divider state.
    logic            r_dbusy;
    logic [CW-1:0]   r_dcnt;
    logic [XLEN-1:0] r_quo, r_rem, r_dvs;
    logic            r_dneg_q, r_dneg_r, r_dspecial;
    logic [XLEN-1:0] r_dspec_val;
    t_item           r_di;
    logic            r_ddone;

    // Output register.
    logic            r_ov;
    logic [XLEN-1:0] r_val, r_tgt;
    logic            r_tk;

    logic adv, s1_load, div_start;
    logic [XLEN-1:0] ma, mb, mulv, divv;
    logic            sgn_a, sgn_b;
    logic [XLEN:0]   trial;

    // Output slot frees when empty or being taken.
    assign adv = !r_ov || !i_stall;

    // Stage 1 accepts a new item when it is empty or will move on, and no divide is busy or done.
    assign s1_load   = (!r_v1 || adv) && !r_dbusy && !r_ddone;
    assign div_start = i_valid && s1_load && (i_item.cls == CLS_DIV);
    assign o_pop     = i_valid && s1_load;

    // Signs and magnitudes for divide.
    assign sgn_a = (i_item.op == OP_DIV || i_item.op == OP_REM) && i_item.a[XLEN-1];
    assign sgn_b = (i_item.op == OP_DIV || i_item.op == OP_REM) && i_item.b[XLEN-1];
    assign ma    = sgn_a ? (XLEN'(0) - i_item.a) : i_item.a;
    assign mb    = sgn_b ? (XLEN'(0) - i_item.b) : i_item.b;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_i1   <= i_item;
            r_prod <= (2*XLEN)'(i_item.a) * (2*XLEN)'(i_item.b);
        end
    end

    // Stage 1 valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_pop && !div_start) begin
            r_v1 <= 1'b1;
        end else if (adv && !r_ddone) begin
            r_v1 <= 1'b0;
        end
    end

    // Multiply high corrections from the unsigned product.
    always_comb begin
        case (r_i1.op)
            OP_MUL:    mulv = r_prod[XLEN-1:0];
            OP_MULH:   mulv = r_prod[2*XLEN-1:XLEN]
                             - (r_i1.a[XLEN-1] ? r_i1.b : '0)
                             - (r_i1.b[XLEN-1] ? r_i1.a : '0);
            OP_MULHSU: mulv = r_prod[2*XLEN-1:XLEN] - (r_i1.a[XLEN-1] ? r_i1.b : '0);
            default:   mulv = r_prod[2*XLEN-1:XLEN];
        endcase
    end

    // Restoring divider, one quotient bit per cycle.
    assign trial = {r_rem, r_quo[XLEN-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_di       <= i_item;
            r_quo      <= ma;
            r_rem      <= '0;
            r_dvs      <= mb;
            r_dneg_q   <= sgn_a ^ sgn_b;
            r_dneg_r   <= sgn_a;
            r_dspecial <= (i_item.b == '0);
            r_dspec_val <= (i_item.op == OP_DIV || i_item.op == OP_DIVU) ? '1 : i_item.a;
        end else if (r_dbusy) begin
            if (!trial[XLEN]) begin
                r_rem <= trial[XLEN-1:0];
                r_quo <= {r_quo[XLEN-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[XLEN-2:0], r_quo[XLEN-1]};
                r_quo <= {r_quo[XLEN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_dcnt  <= '0;
        end else if (div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= CW'(XLEN);
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt - CW'(1);
            if (r_dcnt == CW'(1)) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
        end else if (r_ddone && adv) begin
            r_ddone <= 1'b0;
        end
    end

    // Signed fixups and divide-by-zero results; overflow falls out of the magnitude arithmetic.
    always_comb begin
        if (r_dspecial) begin
            divv = r_dspec_val;
        end else if (r_di.op == OP_DIV || r_di.op == OP_DIVU) begin
            divv = r_dneg_q ? (XLEN'(0) - r_quo) : r_quo;
        end else begin
            divv = r_dneg_r ? (XLEN'(0) - r_rem) : r_rem;
        end
    end

    // Output register: a finished divide wins over stage 1, which waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_ddone || r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_ddone) begin
                r_val <= divv;
                r_tk  <= r_di.taken;
                r_tgt <= r_di.target;
            end else begin
                r_val <= (r_i1.cls == CLS_MUL) ? mulv : r_i1.alu_value;
                r_tk  <= r_i1.taken;
                r_tgt <= r_i1.target;
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_result_value  = r_val;
    assign o_branch_taken  = r_tk;
    assign o_branch_target = r_tgt;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_val)) else $error("output changed");
    a_div_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_dbusy && r_ddone)) else $error("divider busy and done");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dbusy |-> !o_pop) else $error("accepted during divide");
endmodule
